// ===== src/bitplane_line_draw_engine_top_defines.svh =====
// Assertion macros used by the checker file
`ifndef BITPLANE_LINE_DRAW_ENGINE_TOP_DEFINES_SVH
`define BITPLANE_LINE_DRAW_ENGINE_TOP_DEFINES_SVH
// implication checked at every rising clock edge outside reset
`define BLDE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define BLDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/blde_pkg.sv =====
// ----------------------------------------------------------------------------
// blde_pkg
// Shared types and constants for the bitplane line draw engine.
// ----------------------------------------------------------------------------
`default_nettype none
package blde_pkg;
   localparam int FB_BYTES_DEF  = 16384;
   localparam int MAX_COORD_DEF = 1023;
   localparam int CSR_W = 11;
   localparam logic [1:0] FUNC_FILL  = 2'd0;
   localparam logic [1:0] FUNC_POINT = 2'd1;
   localparam logic [1:0] FUNC_LINE  = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;
   localparam logic [1:0] COL_BLACK = 2'd0;
   localparam logic [1:0] COL_WHITE = 2'd1;
   localparam logic [1:0] COL_RED   = 2'd2;
   localparam logic [1:0] COL_NONE  = 2'd3;
   localparam logic [1:0] REG_ORIENT = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  x_start;
      logic [9:0]  y_start;
      logic [9:0]  x_end;
      logic [9:0]  y_end;
      logic [1:0]  color;
      logic [13:0] byte_index;
   } req_type;

   typedef struct packed {
      logic [7:0] bw_byte;
      logic [7:0] red_byte;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/blde_if.sv =====
// ----------------------------------------------------------------------------
// blde_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface blde_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/bitplane_line_draw_engine_top.sv =====
// ----------------------------------------------------------------------------
// bitplane_line_draw_engine_top
// Two-plane 1 bpp framebuffer drawing engine: fill, point, Bresenham line,
// byte read.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass writes zero to all
// FB_BYTES entries, one per cycle, before the first request is taken. Fill
// writes every entry, one per cycle; a point passes the address, read,
// write and step states; a line repeats them per pixel (max(dx,dy)+1 pixels),
// set by the read-modify-write of one address through the single-port plane
// memory with registered read data and the address multiply register; a read
// passes the read and response states and waits for the response to be taken.
`default_nettype none
module bitplane_line_draw_engine_top
   import blde_pkg::*;
#(
   parameter int FB_BYTES  = FB_BYTES_DEF,
   parameter int MAX_COORD = MAX_COORD_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   blde_if.sink                    req,
   blde_if.source                  rsp,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [CSR_W-1:0]   csr_wdata
);
   localparam int AW = $clog2(FB_BYTES);
   localparam int CW = $clog2(MAX_COORD + 1);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_FILL  = 8'b00000100,
      ST_ADDR  = 8'b00001000,
      ST_RD    = 8'b00010000,
      ST_WR    = 8'b00100000,
      ST_STEP  = 8'b01000000,
      ST_RESP  = 8'b10000000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       orient_ff;
   logic [10:0]      width_ff, height_ff;
   logic [AW:0]      cnt_ff, cnt_in;
   logic [1:0]       func_ff, func_in;
   logic [1:0]       color_ff, color_in;
   logic [CW-1:0]    x_ff, x_in, y_ff, y_in, xe_ff, xe_in, ye_ff, ye_in;
   logic signed [CW+2:0] err_ff, err_in, dx_ff, dx_in, dy_ff, dy_in;
   logic             sx_ff, sx_in, sy_ff, sy_in;
   logic [23:0]      addr_ff, addr_in;
   logic             drop_ff, drop_in;
   logic [2:0]       bit_ff, bit_in;
   logic             oor_ff, oor_in;
   logic [7:0]       bw_mem [FB_BYTES];
   logic [7:0]       rd_mem [FB_BYTES];
   logic [7:0]       bw_q, rd_q;
   logic             we;
   logic [AW-1:0]    maddr;
   logic [7:0]       bw_wd, rd_wd, mask;
   rsp_type          rsp_ff;
   logic             rsp_v_ff;
   logic [CW-1:0]    xs_sat, ys_sat, xe_sat, ye_sat;
   logic signed [CW+3:0] e2;
   logic signed [CW+2:0] err_x;
   logic signed [CW+3:0] e2y;
   logic             stepx, stepy, done;

   function automatic logic [CW-1:0] sat(input logic [9:0] v);
      if (32'(v) > MAX_COORD) return CW'(MAX_COORD);
      return CW'(v);
   endfunction

   assign xs_sat = sat(req.data.x_start);
   assign ys_sat = sat(req.data.y_start);
   assign xe_sat = sat(req.data.x_end);
   assign ye_sat = sat(req.data.y_end);
   assign req.ready = (state_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;
   assign mask = 8'h80 >> bit_ff;
   assign e2 = {err_ff, 1'b0};
   assign stepx = (e2 >= (CW+4)'(dy_ff));
   assign err_x = stepx ? err_ff + dy_ff : err_ff;
   assign e2y = {err_x, 1'b0};
   assign stepy = (e2y <= (CW+4)'(dx_ff));
   assign done = (stepx && x_ff == xe_ff) ||
                 (stepy && !(stepx && x_ff == xe_ff) && y_ff == ye_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= 2'd0;
         width_ff  <= 11'd400;
         height_ff <= 11'd300;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIENT: orient_ff <= csr_wdata[1:0];
            REG_WIDTH:  width_ff  <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      func_in = func_ff; color_in = color_ff;
      x_in = x_ff; y_in = y_ff; xe_in = xe_ff; ye_in = ye_ff;
      err_in = err_ff; dx_in = dx_ff; dy_in = dy_ff; sx_in = sx_ff; sy_in = sy_ff;
      addr_in = addr_ff; drop_in = drop_ff; bit_in = bit_ff; oor_in = oor_ff;
      we = 1'b0;
      maddr = addr_ff[AW-1:0];
      bw_wd = bw_q; rd_wd = rd_q;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; maddr = cnt_ff[AW-1:0]; bw_wd = 8'h00; rd_wd = 8'h00;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(FB_BYTES - 1)) begin
               state_in = ST_IDLE; cnt_in = '0;
            end
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               func_in = req.data.func; color_in = req.data.color;
               x_in = xs_sat; y_in = ys_sat; xe_in = xe_sat; ye_in = ye_sat;
               dx_in = (xe_sat >= xs_sat) ? (CW+3)'(xe_sat - xs_sat)
                                          : (CW+3)'(xs_sat - xe_sat);
               dy_in = (ye_sat >= ys_sat) ? -(CW+3)'(ye_sat - ys_sat)
                                          : -(CW+3)'(ys_sat - ye_sat);
               sx_in = xs_sat < xe_sat;
               sy_in = ys_sat < ye_sat;
               addr_in = 24'(req.data.byte_index);
               oor_in = 32'(req.data.byte_index) >= FB_BYTES;
               cnt_in = '0;
               priority if (req.data.func == FUNC_READ) state_in = ST_RD;
               else if (req.data.color == COL_NONE) state_in = ST_IDLE;
               else if (req.data.func == FUNC_FILL) state_in = ST_FILL;
               else state_in = ST_ADDR;
            end
         end
         ST_FILL: begin
            we = 1'b1; maddr = cnt_ff[AW-1:0];
            bw_wd = {8{color_ff[0]}}; rd_wd = {8{color_ff[1]}};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(FB_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_ADDR: begin
            if (func_ff == FUNC_LINE && cnt_ff == '0) begin
               err_in = dx_ff + dy_ff;
               cnt_in = (AW+1)'(1);
            end
            drop_in = (11'(x_ff) >= width_ff) || (11'(y_ff) >= height_ff);
            if (orient_ff[0]) begin
               addr_in = 24'(13'(y_ff >> 3) * width_ff) + 24'(x_ff);
               bit_in = y_ff[2:0];
            end else begin
               addr_in = 24'(13'(y_ff) * 9'((12'(width_ff) + 12'd7) >> 3))
                         + 24'(x_ff >> 3);
               bit_in = x_ff[2:0];
            end
            state_in = ST_RD;
         end
         ST_RD: begin
            if (func_ff == FUNC_READ) state_in = ST_RESP;
            else begin
               if (drop_ff || addr_ff >= 24'(FB_BYTES)) state_in = ST_STEP;
               else state_in = ST_WR;
            end
         end
         ST_WR: begin
            we = 1'b1;
            unique case (color_ff)
               COL_BLACK: begin bw_wd = bw_q & ~mask; rd_wd = rd_q & ~mask; end
               COL_WHITE: begin bw_wd = bw_q | mask;  rd_wd = rd_q & ~mask; end
               COL_RED:   begin bw_wd = bw_q;         rd_wd = rd_q | mask;  end
               default:   begin bw_wd = bw_q;         rd_wd = rd_q;         end
            endcase
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (func_ff != FUNC_LINE || done) state_in = ST_IDLE;
            else begin
               if (stepx) begin
                  err_in = err_ff + dy_ff;
                  x_in = sx_ff ? x_ff + 1'b1 : x_ff - 1'b1;
               end
               if (stepy) begin
                  err_in = err_x + dx_ff;
                  y_in = sy_ff ? y_ff + 1'b1 : y_ff - 1'b1;
               end
               state_in = ST_ADDR;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         bw_mem[maddr] <= bw_wd;
         rd_mem[maddr] <= rd_wd;
      end
      bw_q <= bw_mem[maddr];
      rd_q <= rd_mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (state_ff == ST_RESP) rsp_v_ff <= 1'b1;
         else if (rsp.ready) rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; color_ff <= color_in;
      x_ff <= x_in; y_ff <= y_in; xe_ff <= xe_in; ye_ff <= ye_in;
      err_ff <= err_in; dx_ff <= dx_in; dy_ff <= dy_in; sx_ff <= sx_in; sy_ff <= sy_in;
      addr_ff <= addr_in; drop_ff <= drop_in; bit_ff <= bit_in; oor_ff <= oor_in;
      if (state_ff == ST_RESP) begin
         rsp_ff.bw_byte  <= oor_ff ? 8'h00 : bw_q;
         rsp_ff.red_byte <= oor_ff ? 8'h00 : rd_q;
      end
   end
endmodule
`default_nettype wire

// ===== src/blde_checker.sv =====
// ----------------------------------------------------------------------------
// blde_checker
// Port-level checks of the draw engine handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitplane_line_draw_engine_top_defines.svh"
module blde_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_data
);
   `BLDE_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready, "request taken with response pending")
   `BLDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped")
   `BLDE_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid && rsp_ready, !rsp_valid, "response repeated")
endmodule

bind bitplane_line_draw_engine_top blde_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire
